[hw/rtl/tsm_pkg.sv]
`default_nettype none
package tsm_pkg;

  // Field widths fixed by the item format.
  localparam int VAL_W  = 32;
  localparam int FUNC_W = 2;

  // Default run depth and internal queue depths.
  localparam int RUN_DEPTH_DEF = 32;
  localparam int CMD_DEPTH     = 4;
  localparam int RES_DEPTH     = 2;

  // Function codes on the input port.
  localparam logic [FUNC_W-1:0] FUNC_APPEND_A = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_B = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MERGE    = 2'd2;

  // Decoded operation handed from the front to the back.
  typedef enum logic [1:0] {
    OP_APPEND_A,
    OP_APPEND_B,
    OP_MERGE
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } res_t;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MERGE
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/tsm_fifo.sv]
`default_nettype none
module tsm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [CNTW-1:0] count;
  logic            push_ok;
  logic            pop_ok;

  // Status flags and the head entry.
  assign full    = (count == CNTW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop_ok) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        count <= count + CNTW'(1);
      end else if (pop_ok && !push_ok) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wptr] <= din;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/tsm_front.sv]
`default_nettype none
module tsm_front import tsm_pkg::*; (
  input  wire logic                    push,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                         full,
  output logic                         q_push,
  output cmd_t                         q_cmd,
  input  wire logic                    q_full
);

  logic known;

  // Decode the function code; the unused code is accepted and dropped.
  always_comb begin
    known       = 1'b1;
    q_cmd.op    = OP_MERGE;
    q_cmd.value = value;
    case (func)
      FUNC_APPEND_A: begin
        q_cmd.op = OP_APPEND_A;
      end
      FUNC_APPEND_B: begin
        q_cmd.op = OP_APPEND_B;
      end
      FUNC_MERGE: begin
        q_cmd.op = OP_MERGE;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // A beat is taken whenever the command queue has room.
  assign full   = q_full;
  assign q_push = push && !q_full && known;

endmodule
`default_nettype wire

[hw/rtl/tsm_back.sv]
`default_nettype none
module tsm_back import tsm_pkg::*; #(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cmd_t cmd,
  input  wire logic cmd_empty,
  output logic      cmd_pop,
  output logic      res_push,
  output res_t      res,
  input  wire logic res_full
);

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);

  logic signed [VAL_W-1:0] mem_a [RUN_DEPTH];
  logic signed [VAL_W-1:0] mem_b [RUN_DEPTH];
  logic signed [VAL_W-1:0] rd_a;
  logic signed [VAL_W-1:0] rd_b;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_a_next;
  logic [CW-1:0] cnt_b;
  logic [CW-1:0] cnt_b_next;
  logic [CW-1:0] i;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j;
  logic [CW-1:0] j_next;
  logic          wr_a;
  logic          wr_b;
  logic          a_ok;
  logic          b_ok;
  logic          take_a;
  logic          is_last;

  // Head selection: the first run wins only when strictly smaller.
  assign a_ok   = (i < cnt_a);
  assign b_ok   = (j < cnt_b);
  assign take_a = a_ok && (!b_ok || (rd_a < rd_b));
  assign is_last = take_a ? ((i + CW'(1) == cnt_a) && !b_ok)
                          : ((j + CW'(1) == cnt_b) && !a_ok);

  assign res.value = take_a ? rd_a : rd_b;
  assign res.last  = is_last;

  // Sequencer: an append is handled in the idle state, a merge primes the read
  // ports and then emits one beat per cycle while the result queue has room.
  always_comb begin
    state_next = state;
    cnt_a_next = cnt_a;
    cnt_b_next = cnt_b;
    i_next     = i;
    j_next     = j;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_APPEND_A: begin
              if (cnt_a < CW'(RUN_DEPTH)) begin
                wr_a       = 1'b1;
                cnt_a_next = cnt_a + CW'(1);
              end
            end
            OP_APPEND_B: begin
              if (cnt_b < CW'(RUN_DEPTH)) begin
                wr_b       = 1'b1;
                cnt_b_next = cnt_b + CW'(1);
              end
            end
            OP_MERGE: begin
              if ((cnt_a != '0) || (cnt_b != '0)) begin
                state_next = ST_PRIME;
              end
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_PRIME: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (take_a) begin
            i_next = i + CW'(1);
          end else begin
            j_next = j + CW'(1);
          end
          if (is_last) begin
            state_next = ST_IDLE;
            cnt_a_next = '0;
            cnt_b_next = '0;
            i_next     = '0;
            j_next     = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      cnt_a <= cnt_a_next;
      cnt_b <= cnt_b_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  // Run buffers; the read registers follow the next head index.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a[AW-1:0]] <= cmd.value;
    end
    if (wr_b) begin
      mem_b[cnt_b[AW-1:0]] <= cmd.value;
    end
    rd_a <= mem_a[i_next[AW-1:0]];
    rd_b <= mem_b[j_next[AW-1:0]];
  end

endmodule
`default_nettype wire

[hw/rtl/two_way_sorted_merge.sv]
`default_nettype none
// Channel   Ports                     Handshake
// input     func, value               beat taken when push && !full
// result    value_res, last           beat taken when pop && !empty
//
// The front takes one beat per cycle into a four-entry command queue.
// An append is handled by the back end in its idle state. A merge of N stored
// values is dequeued in the idle state, primes the run buffer read registers,
// then emits its N result beats one per cycle while the result queue has room.
// Reset (rst, synchronous) empties both runs and both queues.
// A full result queue stalls the merge; a full command queue raises full.
module two_way_sorted_merge import tsm_pkg::*; #(
  parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [FUNC_W-1:0]       func,
  input  wire logic signed [VAL_W-1:0] value,
  output logic                         empty,
  input  wire logic                    pop,
  output logic signed [VAL_W-1:0]      value_res,
  output logic                         last
);

  logic                 q_push;
  cmd_t                 q_cmd;
  logic                 q_full;
  logic [$bits(cmd_t)-1:0] q_dout;
  logic                 q_empty;
  logic                 q_pop;
  logic                 r_push;
  res_t                 r_din;
  logic                 r_full;
  logic [$bits(res_t)-1:0] r_dout;
  res_t                 r_head;

  // Front end: decode and enqueue.
  tsm_front u_front (
    .push   (push),
    .func   (func),
    .value  (value),
    .full   (full),
    .q_push (q_push),
    .q_cmd  (q_cmd),
    .q_full (q_full)
  );

  // Command queue between front and back.
  tsm_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // Back end: run buffers and merge sequencer.
  tsm_back #(
    .RUN_DEPTH (RUN_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_t'(q_dout)),
    .cmd_empty (q_empty),
    .cmd_pop   (q_pop),
    .res_push  (r_push),
    .res       (r_din),
    .res_full  (r_full)
  );

  // Result queue toward the consumer.
  tsm_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (r_push),
    .din   (r_din),
    .full  (r_full),
    .pop   (pop),
    .dout  (r_dout),
    .empty (empty)
  );

  assign r_head    = res_t'(r_dout);
  assign value_res = r_head.value;
  assign last      = r_head.last;

endmodule
`default_nettype wire

[verif/tb_two_way_sorted_merge.sv]
`timescale 1ns / 100ps

module tb_two_way_sorted_merge;
  import tsm_pkg::*;

  localparam int RUN_DEPTH    = RUN_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 370;
  localparam int DRAIN_CYCLES = 2 * RUN_DEPTH + 40;
  localparam int CYCLE_LIMIT  = 200000;

  // The selector value with no operation behind it.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  // Receiver behavior: always ready, fixed stall pattern, mostly stalled, coin flip.
  localparam int RX_READY   = 0;
  localparam int RX_PATTERN = 1;
  localparam int RX_SLOW    = 2;
  localparam int RX_COIN    = 3;

  logic                    clk   = 1'b0;
  logic                    rst   = 1'b1;
  logic                    push  = 1'b0;
  logic [FUNC_W-1:0]       func  = FUNC_APPEND_A;
  logic signed [VAL_W-1:0] value = '0;
  logic                    pop   = 1'b0;
  logic                    full;
  logic                    empty;
  logic signed [VAL_W-1:0] value_res;
  logic                    last;

  // Mirror of the two runs and the merged beats still to come.
  logic signed [VAL_W-1:0] first_run_q[$];
  logic signed [VAL_W-1:0] second_run_q[$];
  res_t                    merged_beats_q[$];

  int          mismatch_count = 0;
  int          items_sent     = 0;
  int unsigned cycle_count    = 0;
  int          tx_gap_max     = 0;
  int          burst_left     = 0;
  int          rx_mode        = RX_READY;
  logic [15:0] rx_pattern     = 16'b1101_0011_1011_0110;

  two_way_sorted_merge #(
    .RUN_DEPTH(RUN_DEPTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .func     (func),
    .value    (value),
    .empty    (empty),
    .pop      (pop),
    .value_res(value_res),
    .last     (last)
  );

  always #4 clk = ~clk;

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d merged beats outstanding", $time,
               merged_beats_q.size());
      $display("tb_two_way_sorted_merge NOT OK");
      $finish;
    end
  end

  // Update the mirrored runs for one accepted beat; a merge drains both runs
  // into the list of expected output beats.
  task automatic track_beat(input logic [FUNC_W-1:0] f,
                            input logic signed [VAL_W-1:0] v);
    res_t beat;
    int   ia;
    int   ib;
    int   total;
    ia = 0;
    ib = 0;
    total = first_run_q.size() + second_run_q.size();
    case (f)
      FUNC_APPEND_A: begin
        if (first_run_q.size() < RUN_DEPTH) begin
          first_run_q.push_back(v);
          items_sent++;
        end
      end
      FUNC_APPEND_B: begin
        if (second_run_q.size() < RUN_DEPTH) begin
          second_run_q.push_back(v);
          items_sent++;
        end
      end
      FUNC_MERGE: begin
        items_sent++;
        while (ia + ib < total) begin
          // First run wins only on a strictly smaller head.
          if (ia < first_run_q.size() && ib < second_run_q.size()) begin
            if (first_run_q[ia] < second_run_q[ib]) begin
              beat.value = first_run_q[ia];
              ia++;
            end else begin
              beat.value = second_run_q[ib];
              ib++;
            end
          end else if (ia < first_run_q.size()) begin
            beat.value = first_run_q[ia];
            ia++;
          end else begin
            beat.value = second_run_q[ib];
            ib++;
          end
          beat.last = (ia + ib == total);
          merged_beats_q.push_back(beat);
        end
        first_run_q.delete();
        second_run_q.delete();
      end
      default: begin
      end
    endcase
  endtask

  // Send one input beat. The sender works in bursts with idle gaps between
  // them. push is left high on return so back-to-back beats stay contiguous.
  task automatic send_beat(input logic [FUNC_W-1:0] f,
                           input logic signed [VAL_W-1:0] v);
    int gap;
    bit taken;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push  <= 1'b1;
    func  <= f;
    value <= v;
    // full is stable at the falling edge; the beat moves on the next rising edge.
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    track_beat(f, v);
    burst_left--;
  endtask

  // Receiver stall pattern, updated once per cycle.
  always @(posedge clk) begin
    case (rx_mode)
      RX_READY: pop <= 1'b1;
      RX_PATTERN: begin
        pop <= rx_pattern[0];
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
      end
      RX_SLOW: pop <= ($urandom_range(0, 3) == 0);
      default: pop <= ($urandom_range(0, 1) == 1);
    endcase
  end

  // Compare every output beat with the oldest expected one.
  always @(negedge clk) begin
    if (!rst && pop && !empty) begin
      if (merged_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual value %0d last %0b",
                 $time, value_res, last);
        mismatch_count++;
      end else begin
        if (value_res !== merged_beats_q[0].value) begin
          $display("%0t: value_res mismatch, expected %0d, actual %0d", $time,
                   merged_beats_q[0].value, value_res);
          mismatch_count++;
        end
        if (last !== merged_beats_q[0].last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b", $time,
                   merged_beats_q[0].last, last);
          mismatch_count++;
        end
        void'(merged_beats_q.pop_front());
      end
    end
  end

  // Starting point of an ascending run.
  function automatic longint run_start(input bit narrow);
    if ($urandom_range(0, 7) == 0) return longint'(VAL_MIN);
    if (narrow) return longint'($urandom_range(0, 16)) - 8;
    return longint'(int'($urandom));
  endfunction

  // Next value of an ascending run, saturating at the top of the range.
  function automatic longint run_step(input longint prev, input bit narrow);
    longint nxt;
    if (narrow) nxt = prev + $urandom_range(0, 2);
    else if ($urandom_range(0, 3) == 0) nxt = prev;
    else nxt = prev + $urandom_range(1, 32'h0800_0000);
    if (nxt > longint'(VAL_MAX)) nxt = longint'(VAL_MAX);
    return nxt;
  endfunction

  // Append na values to the first run and nb to the second, interleaved at
  // random. Narrow runs produce many equal heads.
  task automatic load_runs(input int na, input int nb, input bit narrow,
                           input bit in_order);
    longint                  cur_a;
    longint                  cur_b;
    int                      ia;
    int                      ib;
    bit                      take_a;
    logic signed [VAL_W-1:0] v;
    ia = 0;
    ib = 0;
    cur_a = run_start(narrow);
    cur_b = run_start(narrow);
    while (ia < na || ib < nb) begin
      take_a = (ib >= nb) || (ia < na && $urandom_range(0, 1) == 1);
      if (take_a) begin
        if (ia > 0) cur_a = run_step(cur_a, narrow);
        v = in_order ? cur_a[VAL_W-1:0] : $urandom;
        send_beat(FUNC_APPEND_A, v);
        ia++;
      end else begin
        if (ib > 0) cur_b = run_step(cur_b, narrow);
        v = in_order ? cur_b[VAL_W-1:0] : $urandom;
        send_beat(FUNC_APPEND_B, v);
        ib++;
      end
    end
  endtask

  // Merge with nothing stored, and the unused selector.
  task automatic test_empty_merge;
    send_beat(FUNC_MERGE, VAL_MAX);
    send_beat(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_beat(FUNC_UNUSED, 32'h0000_0000);
  endtask

  // Only one run holds values at each merge; a further merge right after finds nothing.
  task automatic test_single_run;
    send_beat(FUNC_APPEND_A, -5);
    send_beat(FUNC_APPEND_A, 7);
    send_beat(FUNC_MERGE, 0);
    send_beat(FUNC_APPEND_B, 100);
    send_beat(FUNC_MERGE, 0);
    send_beat(FUNC_MERGE, 0);
  endtask

  // Range extremes with equal heads at both ends.
  task automatic test_extremes;
    send_beat(FUNC_APPEND_A, VAL_MIN);
    send_beat(FUNC_APPEND_B, VAL_MIN);
    send_beat(FUNC_APPEND_A, 0);
    send_beat(FUNC_APPEND_B, -1);
    send_beat(FUNC_APPEND_A, VAL_MAX);
    send_beat(FUNC_APPEND_B, VAL_MAX);
    send_beat(FUNC_MERGE, VAL_MIN);
  endtask

  // Runs out of order still go through the same head comparison.
  task automatic test_unsorted;
    send_beat(FUNC_APPEND_A, 9);
    send_beat(FUNC_APPEND_A, -9);
    send_beat(FUNC_APPEND_B, 3);
    send_beat(FUNC_APPEND_B, 3);
    send_beat(FUNC_MERGE, 0);
  endtask

  // Both runs filled past their depth; the surplus appends are dropped.
  task automatic test_full_runs;
    tx_gap_max = 3;
    rx_mode = RX_PATTERN;
    load_runs(RUN_DEPTH + 2, RUN_DEPTH + 1, 1'b0, 1'b1);
    send_beat(FUNC_MERGE, $urandom);
  endtask

  // Mostly well-formed load and merge sequences of random content, with
  // noise beats, skipped merges and repeated merges mixed in.
  task automatic test_random_merges;
    int goal;
    int na;
    int nb;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      case ($urandom_range(0, 3))
        0: tx_gap_max = 0;
        1: tx_gap_max = 1;
        2: tx_gap_max = 3;
        default: tx_gap_max = 8;
      endcase
      rx_mode = $urandom_range(RX_READY, RX_COIN);
      na = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      nb = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
      load_runs(na, nb, $urandom_range(0, 2) == 0, $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2)) send_beat(FUNC_UNUSED, $urandom);
      end
      case ($urandom_range(0, 9))
        0: begin
          // Leave the runs loaded so the next sequence appends behind them.
        end
        1: begin
          send_beat(FUNC_MERGE, $urandom);
          send_beat(FUNC_MERGE, $urandom);
        end
        default: send_beat(FUNC_MERGE, $urandom);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_merge();
    test_single_run();
    tx_gap_max = 2;
    rx_mode = RX_COIN;
    test_extremes();
    test_unsorted();
    test_full_runs();
    test_random_merges();

    // Let the last merges drain, then allow for stray beats.
    push <= 1'b0;
    while (merged_beats_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_two_way_sorted_merge OK");
    end else begin
      $display("tb_two_way_sorted_merge NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tsm_pkg.sv
hw/rtl/tsm_fifo.sv
hw/rtl/tsm_front.sv
hw/rtl/tsm_back.sv
hw/rtl/two_way_sorted_merge.sv
verif/tb_two_way_sorted_merge.sv
